/* design/slcan_pkg.sv */
// Package for the slcan text frame parser.
// Character constants, the hex digit decoder and the frame record type.
// No dependencies.
package slcan_pkg;

    localparam int MAX_DATA_BYTES_DEF = 8;

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [4:0] CNT_MAX   = 5'd31;
    localparam logic [4:0] POS_ID_END = 5'd3;
    localparam logic [4:0] POS_LEN   = 5'd4;
    localparam logic [4:0] POS_DATA  = 5'd5;

    typedef struct packed {
        logic [11:0] can_id;
        logic [3:0]  data_count;
        logic [63:0] data_bytes;
    } frame_t;

    // Bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

/* design/slcan_text_frame_parser.sv */
// Top level of the slcan text frame parser: input register, line parser,
// result register. Depends on slcan_pkg and slcan_line_parse.
//
//   channel | direction | payload                              | handshake
//   s_      | in        | s_rx_char[7:0]                       | s_valid/s_ready
//   m_      | out       | m_can_id, m_data_count, m_data_bytes | m_valid/m_ready
//
// One character per cycle while the result side does not stall. The input register
// holds the accepted carriage return; the result register takes the frame from it
// once the result register is free (no valid result, or m_ready), which raises m_valid.
// Synchronous active-low reset clears the line state and the valid flags of both registers.
// A stalled result only holds the input side back when the next character
// would complete another frame.
module slcan_text_frame_parser #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_can_id,
    output logic [3:0]  m_data_count,
    output logic [63:0] m_data_bytes
);
    import slcan_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        out_valid_reg;
    frame_t      out_frame_reg;
    logic        out_free;
    logic        adv;
    logic        frame_hit;
    frame_t      frame;

    slcan_line_parse #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .char_adv  (adv),
        .char_in   (in_char_reg),
        .frame_hit (frame_hit),
        .frame     (frame)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign adv      = in_valid_reg && (!frame_hit || out_free);
    assign s_ready  = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_rx_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= adv && frame_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && frame_hit) begin
            out_frame_reg <= frame;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_can_id     = out_frame_reg.can_id;
    assign m_data_count = out_frame_reg.data_count;
    assign m_data_bytes = out_frame_reg.data_bytes;

endmodule

/* design/slcan_line_parse.sv */
// Line state of the slcan parser: updates on each advanced character and
// flags a completed frame at carriage return.
// Depends on slcan_pkg.
module slcan_line_parse #(
    parameter int MAX_DATA_BYTES = slcan_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 char_adv,
    input  logic [7:0]           char_in,
    output logic                 frame_hit,
    output slcan_pkg::frame_t    frame
);
    import slcan_pkg::*;

    localparam logic [3:0] MaxIdx = 4'(MAX_DATA_BYTES);
    localparam logic [7:0] LenHigh = 8'(48 + MAX_DATA_BYTES);

    logic        seen_t_reg, seen_t_next;
    logic        seen_w_reg, seen_w_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [11:0] id_reg, id_next;
    logic        id_bad_reg, id_bad_next;
    logic [3:0]  len_reg, len_next;
    logic        len_ok_reg, len_ok_next;
    logic [4:0]  pend_reg, pend_next;
    logic [63:0] data_reg, data_next;

    logic [4:0]  pos;
    logic [4:0]  d;
    logic [3:0]  idx;
    logic [4:0]  h;
    logic [7:0]  byte_val;
    logic [5:0]  want_cnt;

    assign want_cnt  = 6'd4 + {1'b0, len_reg, 1'b0};
    assign frame_hit = (char_in == CH_CR) && seen_t_reg && !seen_w_reg && len_ok_reg
                       && ({1'b0, cnt_reg} == want_cnt);
    assign frame.can_id     = id_bad_reg ? 12'd0 : id_reg;
    assign frame.data_count = len_reg;
    assign frame.data_bytes = data_reg;

    assign pos      = cnt_reg + 5'd1;
    assign d        = pos - POS_DATA;
    assign idx      = d[4:1];
    assign h        = hex_value(char_in);
    assign byte_val = (!h[4] && !pend_reg[4]) ? {pend_reg[3:0], h[3:0]} : 8'd0;

    always_comb begin
        seen_t_next = seen_t_reg;
        seen_w_next = seen_w_reg;
        cnt_next    = cnt_reg;
        id_next     = id_reg;
        id_bad_next = id_bad_reg;
        len_next    = len_reg;
        len_ok_next = len_ok_reg;
        pend_next   = pend_reg;
        data_next   = data_reg;
        if (char_adv) begin
            if (char_in == CH_CR) begin
                seen_t_next = 1'b0;
                seen_w_next = 1'b0;
                cnt_next    = 5'd0;
                id_next     = 12'd0;
                id_bad_next = 1'b0;
                len_next    = 4'd0;
                len_ok_next = 1'b0;
                pend_next   = 5'd0;
                data_next   = 64'd0;
            end else begin
                if (char_in == CH_W) begin
                    seen_w_next = 1'b1;
                end
                if (!seen_t_reg) begin
                    if (char_in == CH_T) begin
                        seen_t_next = 1'b1;
                    end
                end else if (cnt_reg != CNT_MAX) begin
                    cnt_next = pos;
                    priority if (pos <= POS_ID_END) begin
                        if (h[4]) begin
                            id_bad_next = 1'b1;
                        end else begin
                            id_next = {id_reg[7:0], h[3:0]};
                        end
                    end else if (pos == POS_LEN) begin
                        if (char_in >= CH_ONE && char_in <= LenHigh) begin
                            len_next    = 4'(char_in - CH_ZERO);
                            len_ok_next = 1'b1;
                        end else begin
                            len_next    = 4'd0;
                            len_ok_next = 1'b0;
                        end
                    end else if (!d[0]) begin
                        pend_next = h;
                    end else begin
                        for (int k = 0; k < 8; k++) begin
                            if (idx == 4'(k) && idx < MaxIdx) begin
                                data_next[8*k +: 8] = data_reg[8*k +: 8] | byte_val;
                            end
                        end
                        pend_next = 5'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_t_reg <= 1'b0;
            seen_w_reg <= 1'b0;
            cnt_reg    <= 5'd0;
            id_reg     <= 12'd0;
            id_bad_reg <= 1'b0;
            len_reg    <= 4'd0;
            len_ok_reg <= 1'b0;
            pend_reg   <= 5'd0;
            data_reg   <= 64'd0;
        end else begin
            seen_t_reg <= seen_t_next;
            seen_w_reg <= seen_w_next;
            cnt_reg    <= cnt_next;
            id_reg     <= id_next;
            id_bad_reg <= id_bad_next;
            len_reg    <= len_next;
            len_ok_reg <= len_ok_next;
            pend_reg   <= pend_next;
            data_reg   <= data_next;
        end
    end

endmodule
